### hdl/morse_keyer_encoder_macros.svh
// Assertion macros used by the Morse keyer encoder top level.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef MORSE_KEYER_ENCODER_MACROS_SVH
`define MORSE_KEYER_ENCODER_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define MKE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define MKE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mke_pkg.sv
// Package of the Morse keyer encoder: codes, field types and the Morse table.
// Depends on nothing; used by the controller, the datapath and the top level.
package mke_pkg;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_OPEN    = 8'd60;
  localparam logic [7:0] CHAR_CLOSE   = 8'd62;
  localparam logic [7:0] CHAR_LOW_A   = 8'd97;
  localparam logic [7:0] CHAR_LOW_Z   = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] ROM_BASE     = 8'd32;
  localparam logic [7:0] ROM_LAST     = 8'd96;

  localparam logic [10:0] DOT_RESET   = 11'd60;
  localparam logic [1:0]  GAP_NORMAL  = 2'd3;
  localparam logic [1:0]  GAP_PROSIGN = 2'd1;
  localparam logic [2:0]  WORD_DOTS   = 3'd7;
  localparam logic [2:0]  CLOSE_DOTS  = 3'd3;
  localparam logic [2:0]  DOT_DOTS    = 3'd1;
  localparam logic [2:0]  DASH_DOTS   = 3'd3;

  localparam logic [11:0] ON_MAX      = 12'd4095;
  localparam logic [12:0] OFF_MAX     = 13'd8191;

  typedef logic [7:0]  character_t;
  typedef logic [10:0] dot_time_t;
  typedef logic [11:0] key_on_t;
  typedef logic [12:0] key_off_t;

  // Elements are left-justified in pat, first element in bit 6, dash is 1.
  typedef struct packed {
    logic [2:0] len;
    logic [6:0] pat;
  } rom_ent_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } mke_cmd_t;

  typedef struct packed {
    logic emits;
    logic is_last;
    logic out_free;
  } mke_status_t;

  function automatic rom_ent_t mke_rom(input logic [6:0] idx);
    rom_ent_t e;
    unique case (idx)
      7'd1:  e = '{3'd6, 7'b1010110};
      7'd2:  e = '{3'd6, 7'b0100100};
      7'd4:  e = '{3'd7, 7'b0001001};
      7'd6:  e = '{3'd5, 7'b0100000};
      7'd7:  e = '{3'd6, 7'b0111100};
      7'd8:  e = '{3'd5, 7'b1011000};
      7'd9:  e = '{3'd6, 7'b1011010};
      7'd11: e = '{3'd5, 7'b0101000};
      7'd12: e = '{3'd6, 7'b1100110};
      7'd13: e = '{3'd6, 7'b1000010};
      7'd14: e = '{3'd6, 7'b0101010};
      7'd15: e = '{3'd5, 7'b1001000};
      7'd16: e = '{3'd5, 7'b1111100};
      7'd17: e = '{3'd5, 7'b0111100};
      7'd18: e = '{3'd5, 7'b0011100};
      7'd19: e = '{3'd5, 7'b0001100};
      7'd20: e = '{3'd5, 7'b0000100};
      7'd21: e = '{3'd5, 7'b0000000};
      7'd22: e = '{3'd5, 7'b1000000};
      7'd23: e = '{3'd5, 7'b1100000};
      7'd24: e = '{3'd5, 7'b1110000};
      7'd25: e = '{3'd5, 7'b1111000};
      7'd26: e = '{3'd6, 7'b1110000};
      7'd27: e = '{3'd6, 7'b1010100};
      7'd29: e = '{3'd5, 7'b1000100};
      7'd31: e = '{3'd6, 7'b0011000};
      7'd32: e = '{3'd6, 7'b0110100};
      7'd33: e = '{3'd2, 7'b0100000};
      7'd34: e = '{3'd4, 7'b1000000};
      7'd35: e = '{3'd4, 7'b1010000};
      7'd36: e = '{3'd3, 7'b1000000};
      7'd37: e = '{3'd1, 7'b0000000};
      7'd38: e = '{3'd4, 7'b0010000};
      7'd39: e = '{3'd3, 7'b1100000};
      7'd40: e = '{3'd4, 7'b0000000};
      7'd41: e = '{3'd2, 7'b0000000};
      7'd42: e = '{3'd4, 7'b0111000};
      7'd43: e = '{3'd3, 7'b1010000};
      7'd44: e = '{3'd4, 7'b0100000};
      7'd45: e = '{3'd2, 7'b1100000};
      7'd46: e = '{3'd2, 7'b1000000};
      7'd47: e = '{3'd3, 7'b1110000};
      7'd48: e = '{3'd4, 7'b0110000};
      7'd49: e = '{3'd4, 7'b1101000};
      7'd50: e = '{3'd3, 7'b0100000};
      7'd51: e = '{3'd3, 7'b0000000};
      7'd52: e = '{3'd1, 7'b1000000};
      7'd53: e = '{3'd3, 7'b0010000};
      7'd54: e = '{3'd4, 7'b0001000};
      7'd55: e = '{3'd3, 7'b0110000};
      7'd56: e = '{3'd4, 7'b1001000};
      7'd57: e = '{3'd4, 7'b1011000};
      7'd58: e = '{3'd4, 7'b1100000};
      7'd59: e = '{3'd5, 7'b1011000};
      7'd60: e = '{3'd5, 7'b1001000};
      7'd61: e = '{3'd6, 7'b1011010};
      7'd63: e = '{3'd6, 7'b0011010};
      7'd64: e = '{3'd6, 7'b0111100};
      default: e = '{3'd0, 7'b0000000};
    endcase
    return e;
  endfunction

endpackage

### hdl/mke_ctrl.sv
// Controller of the Morse keyer encoder: accepts a word, then steps pulses out.
// Depends on mke_pkg for the command and status structs.
module mke_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mke_pkg::mke_status_t status_i,
  output mke_pkg::mke_cmd_t    cmd_o
);
  import mke_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.emits) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free && status_i.is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/mke_dp.sv
// Datapath of the Morse keyer encoder: decode, element shifter, timing, output.
// Depends on mke_pkg for the Morse table, constants and structs.
module mke_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mke_pkg::character_t  character_i,
  input  logic                 cfg_valid_i,
  input  mke_pkg::dot_time_t   cfg_data_i,
  input  mke_pkg::mke_cmd_t    cmd_i,
  output mke_pkg::mke_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mke_pkg::key_on_t     key_on_ms_o,
  output mke_pkg::key_off_t    key_off_ms_o,
  output logic                 last_pulse_o
);
  import mke_pkg::*;

  character_t ch_fold;
  logic [6:0] rom_off;
  rom_ent_t   rom_ent;
  logic       in_range, is_space, is_open, is_close;

  dot_time_t  dot_q;
  logic [1:0] gap_q;
  logic [2:0] rem_q;
  logic [6:0] pat_q;
  logic [2:0] fin_off_q;
  logic       out_valid_q;
  key_on_t    key_on_q;
  key_off_t   key_off_q;
  logic       last_q;

  logic [2:0]  on_dots, off_dots;
  logic [13:0] on_prod, off_prod;
  key_on_t     on_sat;
  key_off_t    off_sat;

  always_comb begin
    ch_fold = character_i;
    if (character_i >= CHAR_LOW_A && character_i <= CHAR_LOW_Z) begin
      ch_fold = character_i - CASE_OFFSET;
    end
    in_range = (ch_fold >= ROM_BASE) && (ch_fold <= ROM_LAST);
    rom_off  = 7'(ch_fold - ROM_BASE);
    rom_ent  = mke_rom(rom_off);
    is_space = (ch_fold == CHAR_SPACE);
    is_open  = (ch_fold == CHAR_OPEN);
    is_close = (ch_fold == CHAR_CLOSE);
  end

  always_comb begin
    if (rem_q != 3'd0) begin
      on_dots  = pat_q[6] ? DASH_DOTS : DOT_DOTS;
      off_dots = DOT_DOTS;
    end else begin
      on_dots  = 3'd0;
      off_dots = fin_off_q;
    end
    on_prod  = 14'(on_dots) * 14'(dot_q);
    off_prod = 14'(off_dots) * 14'(dot_q);
    on_sat   = (on_prod > 14'(ON_MAX)) ? ON_MAX : on_prod[11:0];
    off_sat  = (off_prod > 14'(OFF_MAX)) ? OFF_MAX : off_prod[12:0];
  end

  assign status_o.emits    = in_range && !is_open;
  assign status_o.is_last  = (rem_q == 3'd0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q       <= DOT_RESET;
      gap_q       <= GAP_NORMAL;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dot_q <= cfg_data_i;
      end
      if (cmd_i.accept && in_range) begin
        if (is_close) begin
          gap_q <= GAP_NORMAL;
        end else if (is_open) begin
          gap_q <= GAP_PROSIGN;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (is_space) begin
        rem_q     <= 3'd0;
        fin_off_q <= WORD_DOTS - {1'b0, gap_q};
      end else if (is_close) begin
        rem_q     <= 3'd0;
        fin_off_q <= CLOSE_DOTS - {1'b0, gap_q};
      end else begin
        rem_q     <= rom_ent.len;
        pat_q     <= rom_ent.pat;
        fin_off_q <= {1'b0, gap_q} - 3'd1;
      end
    end else if (cmd_i.emit) begin
      if (rem_q != 3'd0) begin
        rem_q <= rem_q - 3'd1;
      end
      pat_q <= {pat_q[5:0], 1'b0};
    end
    if (cmd_i.emit) begin
      key_on_q  <= on_sat;
      key_off_q <= off_sat;
      last_q    <= (rem_q == 3'd0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_on_ms_o  = key_on_q;
  assign key_off_ms_o = key_off_q;
  assign last_pulse_o = last_q;

endmodule

### hdl/morse_keyer_encoder.sv
// Morse keyer encoder top level: joins the controller and the datapath.
// Depends on mke_pkg, mke_ctrl, mke_dp and morse_keyer_encoder_macros.svh.
// A character of n elements gives n + 1 pulses, one per cycle while out_stall_i is low.
// A taken word moves the controller to its emit state, and each pulse is registered into the
// output; a dropped character or '<' gives no pulse and leaves the controller idle.
// Reset clears the controller, the output valid, dot time to 60 ms and the gap to 3.
module morse_keyer_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mke_pkg::character_t character_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mke_pkg::key_on_t    key_on_ms_o,
  output mke_pkg::key_off_t   key_off_ms_o,
  output logic                last_pulse_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  mke_pkg::dot_time_t  cfg_data_i
);
  import mke_pkg::*;
  `include "morse_keyer_encoder_macros.svh"

  mke_cmd_t    cmd;
  mke_status_t status;

  assign cfg_ready_o = 1'b1;

  mke_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mke_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .character_i  (character_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_on_ms_o  (key_on_ms_o),
    .key_off_ms_o (key_off_ms_o),
    .last_pulse_o (last_pulse_o)
  );

  `MKE_ASSERT(a_no_emit_while_taking, !(cmd.emit && !in_stall_o), "pulse emitted while idle")
  `MKE_ASSERT_NEXT(a_last_returns_idle, cmd.emit && status.is_last, !in_stall_o, "no idle after last pulse")
  `MKE_ASSERT_NEXT(a_silent_word_idle, cmd.accept && !status.emits, !in_stall_o, "silent word left busy")

endmodule

### test/tb_top.sv
// Self-checking testbench of the Morse keyer encoder: character words in, key pulses out.
// Depends on mke_pkg and the morse_keyer_encoder RTL; reads no files.
// Pulses are predicted per accepted word and checked in order under random idling.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mke_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TEXT_PHASES   = 5;
  localparam int PHASE_ITEMS   = 40;
  localparam byte DASH_GLYPH   = "-";

  typedef struct packed {
    key_on_t  on_ms;
    key_off_t off_ms;
    logic     last;
  } pulse_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  character_t character_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  key_on_t    key_on_ms_o;
  key_off_t   key_off_ms_o;
  logic       last_pulse_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  dot_time_t  cfg_data_i  = '0;

  string morse_code [0:64] = '{
    "", "-.-.--", ".-..-.", "", "...-..-", "", ".-...", ".----.",
    "-.--.", "-.--.-", "", ".-.-.", "--..--", "-....-", ".-.-.-", "-..-.",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----.", "---...", "-.-.-.", "", "-...-", "", "..--..",
    ".--.-.", ".-", "-...", "-.-.", "-..", ".", "..-.", "--.",
    "....", "..", ".---", "-.-", ".-..", "--", "-.", "---",
    ".--.", "--.-", ".-.", "...", "-", "..-", "...-", ".--",
    "-..-", "-.--", "--..", "-.--.", "-..-.", "-.--.-", "", "..--.-",
    ".----."
  };

  pulse_t    pending_pulses [$];
  pulse_t    want_pulse;
  dot_time_t dot_ms         = DOT_RESET;
  int        gap_dots       = int'(GAP_NORMAL);
  int        error_count    = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  bit        in_held        = 1'b0;

  morse_keyer_encoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .character_i  (character_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_on_ms_o  (key_on_ms_o),
    .key_off_ms_o (key_off_ms_o),
    .last_pulse_o (last_pulse_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int scale_ms(input int dots, input int cap);
    int t;
    t = dots * int'(dot_ms);
    return (t > cap) ? cap : t;
  endfunction

  function automatic void push_pulse(input int on_dots, input int off_dots, input logic last);
    pulse_t p;
    p.on_ms  = key_on_t'(scale_ms(on_dots, int'(ON_MAX)));
    p.off_ms = key_off_t'(scale_ms(off_dots, int'(OFF_MAX)));
    p.last   = last;
    pending_pulses.push_back(p);
  endfunction

  function automatic void encode_char(input character_t c);
    character_t ch;
    string      code;
    ch = c;
    if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ch = ch - CASE_OFFSET;
    if (ch < ROM_BASE || ch > ROM_LAST) return;
    if (ch == CHAR_SPACE) begin
      push_pulse(0, int'(WORD_DOTS) - gap_dots, 1'b1);
    end else if (ch == CHAR_OPEN) begin
      gap_dots = int'(GAP_PROSIGN);
    end else if (ch == CHAR_CLOSE) begin
      push_pulse(0, int'(CLOSE_DOTS) - gap_dots, 1'b1);
      gap_dots = int'(GAP_NORMAL);
    end else begin
      code = morse_code[ch - ROM_BASE];
      for (int i = 0; i < code.len(); i++) begin
        push_pulse((code[i] == DASH_GLYPH) ? int'(DASH_DOTS) : int'(DOT_DOTS), 1, 1'b0);
      end
      push_pulse(0, gap_dots - 1, 1'b1);
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected pulse, expected none, got on %0d off %0d last %0b",
                 $time, key_on_ms_o, key_off_ms_o, last_pulse_o);
        error_count++;
      end else begin
        want_pulse = pending_pulses.pop_front();
        check_field("key_on_ms", 32'(want_pulse.on_ms), 32'(key_on_ms_o));
        check_field("key_off_ms", 32'(want_pulse.off_ms), 32'(key_off_ms_o));
        check_field("last_pulse", 32'(want_pulse.last), 32'(last_pulse_o));
      end
    end
    out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  task automatic drop_valid();
    if (in_held) in_valid_i <= 1'b0;
    in_held = 1'b0;
  endtask

  task automatic send_char(input character_t c);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      drop_valid();
      @(posedge clk_i);
    end
    if (!in_held) in_valid_i <= 1'b1;
    in_held = 1'b1;
    character_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_char(c);
  endtask

  task automatic drain();
    drop_valid();
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dot_time(input dot_time_t ms);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ms;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dot_ms = ms;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic character_t random_glyph();
    if ($urandom_range(2, 0) == 0) return CHAR_LOW_A + character_t'($urandom_range(25, 0));
    return character_t'($urandom_range(int'(ROM_LAST), int'(ROM_BASE) + 1));
  endfunction

  // Runs at the reset dot time, so the register default is checked too.
  task automatic test_directed_text();
    character_t words [24] = '{
      "A", "z", "0", "$", "#", ",", "?", "-", "@", "_", 8'd96, " ",
      "<", " ", "S", "O", "S", ">", ">", 8'd0, 8'd31, 8'd123, 8'd255, 8'd127
    };
    foreach (words[i]) send_char(words[i]);
    drain();
  endtask

  task automatic test_random_text(input dot_time_t ms, input int send_pct,
                                  input int recv_pct);
    int sent;
    int pick;
    int body;
    sent = 0;
    write_dot_time(ms);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        body = $urandom_range(3, 1);
        send_char(CHAR_OPEN);
        repeat (body) send_char(random_glyph());
        send_char(CHAR_CLOSE);
        sent += body + 2;
      end else if (pick < 25) begin
        send_char(CHAR_SPACE);
        sent++;
      end else if (pick < 35) begin
        send_char(character_t'($urandom_range(255, 0)));
        sent++;
      end else begin
        send_char(random_glyph());
        sent++;
      end
    end
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    dot_time_t phase_ms [TEXT_PHASES];
    int        phase_send [TEXT_PHASES];
    int        phase_recv [TEXT_PHASES];
    phase_ms   = '{11'd1200, 11'd1, 11'd2047, 11'd0, dot_time_t'($urandom_range(1200, 1))};
    phase_send = '{0, 59, 0, 6, 0};
    phase_recv = '{0, 0, 59, 6, 0};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_text();
    for (int i = 0; i < TEXT_PHASES; i++) begin
      test_random_text(phase_ms[i], phase_send[i], phase_recv[i]);
    end
    drain();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
